### sv/modbus_rtu_request_deframer_assert.svh
// Assertion macros shared by the Modbus RTU request deframer modules
`ifndef MODBUS_RTU_REQUEST_DEFRAMER_ASSERT_SVH
`define MODBUS_RTU_REQUEST_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge
`define MRD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define MRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define MRD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define MRD_ASSERT_ALWAYS(label, cond, msg)
`define MRD_ASSERT_NEXT(label, ante, cons, msg)
`define MRD_ASSERT_IMPLY(label, ante, cons, msg)

`endif

`endif

### sv/mrd_pkg.sv
// Types and constants of the Modbus RTU request deframer
package mrd_pkg;

  // Frame status codes on the result channel
  typedef enum logic [1:0] {
    STATUS_COLLECT = 2'd0,
    STATUS_GOOD    = 2'd1,
    STATUS_ERROR   = 2'd2
  } mrd_status_t;

  // Classification of one byte by the front part
  typedef enum logic [1:0] {
    KIND_COLLECT = 2'd0,
    KIND_ERROR   = 2'd1,
    KIND_CHECK   = 2'd2
  } mrd_kind_t;

  // Function codes and frame lengths
  localparam logic [7:0] FC_WRITE_COILS = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS  = 8'h10;
  localparam logic [9:0] LEN_EXCEPTION  = 10'd5;
  localparam logic [9:0] LEN_FIXED      = 10'd8;
  localparam logic [9:0] LEN_WRITE_BASE = 10'd9;
  localparam logic [8:0] IDX_FC_READY   = 9'd3;
  localparam logic [8:0] IDX_COUNT_BYTE = 9'd6;
  localparam logic [8:0] IDX_LAST_MAX   = 9'd263;

  // CRC-16/MODBUS
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // One classified byte passed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    mrd_kind_t  kind;
    logic       fold;
    logic [7:0] unit_id;
    logic [7:0] function_code;
  } mrd_item_t;

endpackage

### sv/mrd_if.sv
// Channel interfaces for received bytes and deframer results
interface mrd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [1:0] frame_status;
  logic       last;
  logic [7:0] unit_id;
  logic [7:0] function_code;

  modport source (
    output valid, output data_byte, output byte_index, output frame_status,
    output last, output unit_id, output function_code, input ready
  );
  modport sink (
    input valid, input data_byte, input byte_index, input frame_status,
    input last, input unit_id, input function_code, output ready
  );
endinterface

### sv/modbus_rtu_request_deframer.sv
// Top level of the Modbus RTU request deframer
//
// Accepts one received request byte per cycle when neither side stalls, a rate set by the
// combinational front classifier and the byte-wide CRC update in the back, and returns one
// result per byte: the byte itself, its position in the frame, the frame's unit id and
// function code, and a status that marks a good frame end (CRC matches) or an error flush.
// A front part keeps the frame position and header and decides the expected length from
// the function code; a two-entry queue carries each classified byte to a back part that
// folds it into CRC-16/MODBUS and loads the output register. Each byte is registered in a
// queue slot, then in the output register, and either side may stall without losing a
// byte. MAX_FRAME_BYTES sets the longest frame length accepted before an error is flagged.
module modbus_rtu_request_deframer #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  mrd_rx_if.sink    in_ch,
  mrd_res_if.source out_ch
);
  import mrd_pkg::*;

  logic      push_valid;
  logic      push;
  logic      q_not_full;
  logic      q_not_empty;
  logic      pop;
  mrd_item_t push_item;
  mrd_item_t pop_item;

  assign push = push_valid && q_not_full;

  // Classify incoming bytes
  mrd_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (q_not_full)
  );

  // Decouple front and back
  mrd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .not_full  (q_not_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  // Check CRC and deliver results
  mrd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_not_empty),
    .item       (pop_item),
    .item_pop   (pop),
    .out_ch     (out_ch)
  );

endmodule

### sv/mrd_front.sv
// Front part: tracks frame position and length, classifies each byte
module mrd_front #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  mrd_rx_if.sink             in_ch,
  output logic               push_valid,
  output mrd_pkg::mrd_item_t push_item,
  input  logic               push_ready
);
  import mrd_pkg::*;

  localparam logic [9:0] MaxLen = 10'(MAX_FRAME_BYTES);

  logic [8:0]  count_r, count_nxt;
  logic [23:0] hdr_r, hdr_nxt;
  logic [23:0] hdr_new;
  logic [8:0]  cnt;
  logic [9:0]  exp_len;
  logic        fc_bad;
  logic        accept;
  mrd_kind_t   kind;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign push_valid  = in_ch.valid;
  assign cnt         = count_r + 9'd1;

  // Capture header bytes into a working copy
  always_comb begin
    hdr_new = hdr_r;
    if (count_r == 9'd0) begin
      hdr_new[7:0] = in_ch.rx_byte;
    end else if (count_r == 9'd1) begin
      hdr_new[15:8] = in_ch.rx_byte;
    end else if (count_r == IDX_COUNT_BYTE) begin
      hdr_new[23:16] = in_ch.rx_byte;
    end
  end

  // Decode expected length from the function code
  always_comb begin
    exp_len = 10'd0;
    fc_bad  = 1'b0;
    if (hdr_new[15]) begin
      exp_len = LEN_EXCEPTION;
    end else begin
      unique case (hdr_new[15:8]) inside
        [8'h01:8'h06]: begin
          exp_len = LEN_FIXED;
        end
        FC_WRITE_COILS, FC_WRITE_REGS: begin
          if (count_r >= IDX_COUNT_BYTE) begin
            exp_len = LEN_WRITE_BASE + {2'b00, hdr_new[23:16]};
          end
        end
        default: begin
          fc_bad = 1'b1;
        end
      endcase
    end
  end

  // Classify the byte
  always_comb begin
    kind = KIND_COLLECT;
    if (count_r >= IDX_FC_READY) begin
      if (fc_bad) begin
        kind = KIND_ERROR;
      end else if (exp_len != 10'd0) begin
        if (exp_len > MaxLen) begin
          kind = KIND_ERROR;
        end else if ({1'b0, cnt} >= exp_len) begin
          kind = KIND_CHECK;
        end
      end
    end
  end

  // Build the queue entry
  always_comb begin
    push_item.data_byte     = in_ch.rx_byte;
    push_item.byte_index    = count_r[7:0];
    push_item.kind          = kind;
    push_item.fold          = (count_r >= 9'd2);
    push_item.unit_id       = (count_r >= 9'd1) ? hdr_new[7:0] : 8'h00;
    push_item.function_code = (count_r >= 9'd2) ? hdr_new[15:8] : 8'h00;
  end

  // Advance or restart the frame
  always_comb begin
    count_nxt = count_r;
    hdr_nxt   = hdr_r;
    if (accept) begin
      if (kind == KIND_COLLECT) begin
        count_nxt = cnt;
        hdr_nxt   = hdr_new;
      end else begin
        count_nxt = 9'd0;
        hdr_nxt   = 24'h000000;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 9'd0;
      hdr_r   <= 24'h000000;
    end else begin
      count_r <= count_nxt;
      hdr_r   <= hdr_nxt;
    end
  end

`include "modbus_rtu_request_deframer_assert.svh"

  `MRD_ASSERT_ALWAYS(a_count_range, count_r <= IDX_LAST_MAX, "frame count out of range")
  `MRD_ASSERT_NEXT(a_restart, accept && (kind != KIND_COLLECT), count_r == 9'd0, "frame not restarted")

endmodule

### sv/mrd_queue.sv
// Short queue of classified bytes between front and back
module mrd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mrd_pkg::mrd_item_t push_item,
  output logic               not_full,
  input  logic               pop,
  output logic               not_empty,
  output mrd_pkg::mrd_item_t pop_item
);
  import mrd_pkg::*;

  localparam logic [QUEUE_PTR_W:0] DepthCnt = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);

  mrd_item_t              slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_PTR_W:0]   fill_r, fill_nxt;

  assign not_full  = (fill_r != DepthCnt);
  assign not_empty = (fill_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

`include "modbus_rtu_request_deframer_assert.svh"

  `MRD_ASSERT_IMPLY(a_no_overflow, push, not_full, "push into full queue")
  `MRD_ASSERT_IMPLY(a_no_underflow, pop, not_empty, "pop from empty queue")

endmodule

### sv/mrd_back.sv
// Back part: runs the CRC, settles the frame status, holds the result
module mrd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  mrd_pkg::mrd_item_t item,
  output logic               item_pop,
  mrd_res_if.source          out_ch
);
  import mrd_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] trail_r, trail_nxt;
  logic [15:0] crc_fold;
  logic [15:0] trail_new;
  logic        out_valid_r, out_valid_nxt;
  mrd_status_t status;

  logic [7:0] data_r, index_r, unit_r, fc_r;
  logic [1:0] status_r;

  // Fold one byte into a CRC-16/MODBUS value
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign item_pop = item_valid && (!out_valid_r || out_ch.ready);

  // Fold the byte leaving the two-byte window, then check
  always_comb begin
    crc_fold  = item.fold ? crc_byte(crc_r, trail_r[15:8]) : crc_r;
    trail_new = {trail_r[7:0], item.data_byte};
    unique case (item.kind)
      KIND_COLLECT: status = STATUS_COLLECT;
      KIND_ERROR:   status = STATUS_ERROR;
      KIND_CHECK:   status = ({trail_new[7:0], trail_new[15:8]} == crc_fold) ?
                             STATUS_GOOD : STATUS_ERROR;
      default:      status = STATUS_ERROR;
    endcase
  end

  // Update CRC state, restart it at frame end
  always_comb begin
    crc_nxt   = crc_r;
    trail_nxt = trail_r;
    if (item_pop) begin
      if (status == STATUS_COLLECT) begin
        crc_nxt   = crc_fold;
        trail_nxt = trail_new;
      end else begin
        crc_nxt   = CRC_INIT;
        trail_nxt = 16'h0000;
      end
    end
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (item_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      trail_r     <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      trail_r     <= trail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (item_pop) begin
      data_r   <= item.data_byte;
      index_r  <= item.byte_index;
      status_r <= status;
      unit_r   <= item.unit_id;
      fc_r     <= item.function_code;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.data_byte     = data_r;
  assign out_ch.byte_index    = index_r;
  assign out_ch.frame_status  = status_r;
  assign out_ch.last          = (status_r != STATUS_COLLECT);
  assign out_ch.unit_id       = unit_r;
  assign out_ch.function_code = fc_r;

`include "modbus_rtu_request_deframer_assert.svh"

  `MRD_ASSERT_NEXT(a_crc_restart, item_pop && (item.kind != KIND_COLLECT), (crc_r == CRC_INIT) && (trail_r == 16'h0000), "CRC not restarted at frame end")

endmodule
